// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the checker files.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PSCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pscc assertion failed");

// next-cycle implication, disabled while reset is low
`define PSCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pscc assertion failed");

`endif

// ===== hw/rtl/pscc_pkg.sv =====
// Shared types and defaults for the prime sieve cell chain.
// No dependencies; compile first.
`default_nettype none

package pscc_pkg;

	localparam int NUM_CELLS_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 16;

	// fate of a candidate as it walks the chain
	typedef enum logic [1:0] {
		ST_LIVE,
		ST_DROP,
		ST_STORED
	} tok_status_t;

	typedef struct packed {
		logic        valid;
		tok_status_t status;
	} token_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic en;
		logic clr;
		logic bit_valid;
		logic din;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_LAUNCH,
		S_WALK
	} ctrl_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pscc_cand_if.sv =====
// Candidate stream: valid/ready handshake carrying one number per beat.
// Uses pscc_pkg for the default width.
`default_nettype none

interface pscc_cand_if #(
	parameter int VALUE_WIDTH = pscc_pkg::VALUE_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pscc_prime_if.sv =====
// Result stream: valid/ready handshake carrying a survivor and its overflow flag.
// Uses pscc_pkg for the default width.
`default_nettype none

interface pscc_prime_if #(
	parameter int VALUE_WIDTH = pscc_pkg::VALUE_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] prime_value;
	logic                   overflow;

	modport source (output valid, output prime_value, output overflow, input ready);
	modport sink   (input valid, input prime_value, input overflow, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pscc_cell.sv =====
// One sieve cell: stored prime, bit-serial remainder, token stage.
// Depends on pscc_pkg.
`default_nettype none

module pscc_cell #(
	parameter int VALUE_WIDTH = pscc_pkg::VALUE_WIDTH_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  pscc_pkg::cell_ctrl_t       ctrl,
	input  wire  [VALUE_WIDTH-1:0]     value_bus,
	input  pscc_pkg::token_t           tok_in,
	output pscc_pkg::token_t           tok_out
);

	logic                   used_q;
	logic [VALUE_WIDTH-1:0] prime_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] rem_d;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   divisor;
	logic [VALUE_WIDTH:0]   diff;
	pscc_pkg::token_t       tok_q;
	pscc_pkg::token_t       tok_d;
	logic                   store;

	// restoring step, MSB first; a stored zero leaves the plain prefix
	assign trial   = {rem_q, ctrl.din};
	assign divisor = {1'b0, prime_q};
	assign diff    = trial - divisor;
	assign rem_d   = (trial >= divisor) ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];

	always_comb begin
		tok_d = tok_in;
		store = 1'b0;
		if (tok_in.valid && tok_in.status == pscc_pkg::ST_LIVE) begin
			if (!used_q) begin
				tok_d.status = pscc_pkg::ST_STORED;
				store        = 1'b1;
			end else if (rem_q == '0) begin
				tok_d.status = pscc_pkg::ST_DROP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q  <= '{valid: 1'b0, status: pscc_pkg::ST_LIVE};
		end else if (ctrl.en) begin
			tok_q <= tok_d;
			if (store) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			if (store) begin
				prime_q <= value_bus;
			end
			if (ctrl.clr) begin
				rem_q <= '0;
			end else if (ctrl.bit_valid) begin
				rem_q <= rem_d;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pscc_ctrl.sv =====
// Sequencer: takes a candidate, streams its bits to the cells, launches
// the token and holds the result register. Depends on pscc_pkg and the stream interfaces.
`default_nettype none

module pscc_ctrl #(
	parameter int VALUE_WIDTH = pscc_pkg::VALUE_WIDTH_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	pscc_cand_if.sink                  cand,
	pscc_prime_if.source               prime,
	input  pscc_pkg::token_t           tail,
	output pscc_pkg::token_t           launch,
	output pscc_pkg::cell_ctrl_t       ctrl,
	output logic [VALUE_WIDTH-1:0]     value_bus
);

	localparam int CntW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
	localparam logic [CntW-1:0] CntLast = CntW'(VALUE_WIDTH - 1);

	pscc_pkg::ctrl_state_t  state_q;
	pscc_pkg::ctrl_state_t  state_d;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH-1:0] sh_q;
	logic [CntW-1:0]        cnt_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_ovf_q;
	logic                   en;
	logic                   accept;
	logic                   emit;

	// freeze the chain only when a result is due and the output is still full
	assign en     = !(tail.valid && tail.status != pscc_pkg::ST_DROP &&
	                  out_valid_q && !prime.ready);
	assign accept = cand.valid && cand.ready;
	assign emit   = en && tail.valid && tail.status != pscc_pkg::ST_DROP;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pscc_pkg::S_IDLE: begin
				if (cand.valid) begin
					state_d = pscc_pkg::S_DIV;
				end
			end
			pscc_pkg::S_DIV: begin
				if (cnt_q == CntLast) begin
					state_d = pscc_pkg::S_LAUNCH;
				end
			end
			pscc_pkg::S_LAUNCH: begin
				state_d = pscc_pkg::S_WALK;
			end
			pscc_pkg::S_WALK: begin
				if (tail.valid) begin
					state_d = pscc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pscc_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cand.ready     = (state_q == pscc_pkg::S_IDLE) && en;
		launch.valid   = (state_q == pscc_pkg::S_LAUNCH);
		launch.status  = pscc_pkg::ST_LIVE;
		ctrl.en        = en;
		ctrl.clr       = accept;
		ctrl.bit_valid = (state_q == pscc_pkg::S_DIV);
		ctrl.din       = sh_q[VALUE_WIDTH-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pscc_pkg::S_IDLE;
		end else if (en) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= cand.value;
			sh_q  <= cand.value;
			cnt_q <= '0;
		end else if (en && state_q == pscc_pkg::S_DIV) begin
			sh_q  <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && prime.ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= val_q;
			out_ovf_q   <= (tail.status == pscc_pkg::ST_LIVE);
		end
	end

	assign value_bus         = val_q;
	assign prime.valid       = out_valid_q;
	assign prime.prime_value = out_value_q;
	assign prime.overflow    = out_ovf_q;

endmodule

`default_nettype wire

// ===== hw/rtl/prime_sieve_cell_chain.sv =====
// Top level of the prime sieve: sequencer plus a row of sieve cells.
// Depends on pscc_pkg, the stream interfaces, pscc_ctrl and pscc_cell.
//
// Usage:
//   cand  : sink, one candidate number per beat, meant to rise from 2.
//   prime : source, one beat per survivor: the number and an overflow flag
//           that is set when every cell was full and the number was not kept.
//   A candidate that some stored prime divides gives no beat at all.
// Timing:
//   A candidate is shifted into all cells one bit per cycle while the chain
//   is not frozen (VALUE_WIDTH remainder steps), then a token walks the
//   chain one cell per cycle, also only while not frozen, and settles at the
//   first free cell, at a divisor, or off the end. A new candidate is
//   taken only once the last token has left the chain, a pace set by the
//   bit-serial remainder and the token walk.
// Reset: arst_n clears all cells to empty and drops any beat in flight.
// Stall: the result sits in an output register; the next candidate may enter
//   meanwhile, and the chain freezes only when its result is due while the
//   previous one is still untaken.
`default_nettype none

module prime_sieve_cell_chain #(
	parameter int NUM_CELLS   = pscc_pkg::NUM_CELLS_DEF,
	parameter int VALUE_WIDTH = pscc_pkg::VALUE_WIDTH_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	pscc_cand_if.sink    cand,
	pscc_prime_if.source prime
);

	pscc_pkg::token_t       tok [NUM_CELLS+1];
	pscc_pkg::cell_ctrl_t   ctrl;
	logic [VALUE_WIDTH-1:0] value_bus;

	pscc_ctrl #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand      (cand),
		.prime     (prime),
		.tail      (tok[NUM_CELLS]),
		.launch    (tok[0]),
		.ctrl      (ctrl),
		.value_bus (value_bus)
	);

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		pscc_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.value_bus (value_bus),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1])
		);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pscc_checker.sv =====
// Port-level checks for the prime sieve cell chain, bound to the top level.
// Depends on assert_macros.svh and pscc_pkg.
`default_nettype none
`include "assert_macros.svh"

module pscc_checker #(
	parameter int VALUE_WIDTH = pscc_pkg::VALUE_WIDTH_DEF
) (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   cand_valid,
	input wire                   cand_ready,
	input wire                   prime_valid,
	input wire                   prime_ready,
	input wire [VALUE_WIDTH-1:0] prime_value,
	input wire                   overflow
);

	logic cand_acc;

	assign cand_acc = cand_valid && cand_ready;

	// a stalled result beat holds
	`PSCC_ASSERT_NXT(a_hold, clk, arst_n, prime_valid && !prime_ready, prime_valid && $stable(prime_value) && $stable(overflow))
	// one candidate in flight at a time
	`PSCC_ASSERT_NXT(a_busy, clk, arst_n, cand_acc, !cand_ready)
	// no result can appear right after a candidate enters
	`PSCC_ASSERT_NXT(a_lat, clk, arst_n, cand_acc, !$rose(prime_valid))

endmodule

bind prime_sieve_cell_chain pscc_checker #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_pscc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cand_valid  (cand.valid),
	.cand_ready  (cand.ready),
	.prime_valid (prime.valid),
	.prime_ready (prime.ready),
	.prime_value (prime.prime_value),
	.overflow    (prime.overflow)
);

`default_nettype wire
